// ----- sv/mcssr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcssr_pkg
// Shared types and constants for the multi-channel soft-start ramp block.
// ----------------------------------------------------------------------------
package mcssr_pkg;

    // Default configuration of the block.
    localparam int unsigned DEF_CHANNELS  = 7;
    localparam int unsigned DEF_TIME_BITS = 32;
    localparam int unsigned DEF_FRAC_BITS = 16;

    // Width of the channel field of an input transfer.
    localparam int unsigned CH_BITS = 3;

    // Operation codes of the input transfer.
    localparam logic OP_QUERY   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

// ----- sv/mcssr_ram.sv -----
// ----------------------------------------------------------------------------
// mcssr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mcssr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mcssr_div.sv -----
// ----------------------------------------------------------------------------
// mcssr_div
// Iterative restoring divider giving num * 2^FRAC_BITS / den for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcssr_div #(
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TIME_BITS-1:0] i_num,
    input  logic [TIME_BITS-1:0] i_den,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quot
);

    localparam int unsigned CW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [TIME_BITS-1:0] r_rem;
    logic [TIME_BITS-1:0] r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [TIME_BITS:0]   w_shift;
    logic [TIME_BITS:0]   w_diff;
    logic                 w_fits;

    // One restoring step: shift the remainder and try the subtraction.
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_diff  = w_shift - {1'b0, r_den};
        w_fits  = (w_shift >= {1'b0, r_den});
    end

    // Control: count the quotient bits and flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fits ? w_diff[TIME_BITS-1:0] : w_shift[TIME_BITS-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- sv/multi_channel_soft_start_ramp.sv -----
// ----------------------------------------------------------------------------
// multi_channel_soft_start_ramp
// Soft-start ramp channels: each query of a valid channel returns elapsed /
// duration as a fixed-point fraction, saturated at full scale.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries an opcode, a channel number, a ramp duration and
// the current microsecond timer. A query of an unarmed channel arms it and
// latches the timer as its start time; every valid query then returns one
// output transfer with the ramp fraction (FRAC_BITS fractional bits) and a
// done flag. A release disarms the channel and produces no output transfer.
// A query of a channel number at or beyond CHANNELS returns zero.
// Start times live in a RAM with a registered read; armed bits are flops.
// One item is handled at a time. A release is done in the idle state, a
// query of an invalid channel goes straight to the finish state, a saturated
// query passes through the read state first, and a query that needs division
// also waits in the divide state for the one-bit-per-cycle divider.
// A finished result sits in the output register; the block accepts the next
// item while it waits, and holds a second result until the receiver takes
// the first. Reset clears all armed bits and the output valid flag.
// ----------------------------------------------------------------------------
module multi_channel_soft_start_ramp #(
    parameter int unsigned CHANNELS  = mcssr_pkg::DEF_CHANNELS,
    parameter int unsigned TIME_BITS = mcssr_pkg::DEF_TIME_BITS,
    parameter int unsigned FRAC_BITS = mcssr_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [mcssr_pkg::CH_BITS-1:0] i_channel,
    input  logic [TIME_BITS-1:0]          i_duration_us,
    input  logic [TIME_BITS-1:0]          i_now_us,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [FRAC_BITS:0]            o_ramp_fraction,
    output logic                          o_ramp_done
);

    import mcssr_pkg::*;

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [FRAC_BITS:0] FULL_SCALE = {1'b1, {FRAC_BITS{1'b0}}};

    t_state               r_state, n_state;
    logic [CHANNELS-1:0]  r_armed, n_armed;
    logic [AW-1:0]        r_addr;
    logic [TIME_BITS-1:0] r_dur;
    logic [TIME_BITS-1:0] r_now;
    logic [FRAC_BITS:0]   r_frac, n_frac;
    logic                 r_out_valid, n_out_valid;
    logic [FRAC_BITS:0]   r_out_frac;
    logic                 r_out_done;

    logic                 w_accept;
    logic                 w_ch_ok;
    logic [AW-1:0]        w_addr;
    logic [TIME_BITS-1:0] w_rdata;
    logic [TIME_BITS-1:0] w_start;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_full;
    logic                 w_we;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [FRAC_BITS-1:0] w_quot;
    logic                 w_load_out;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ch_ok    = (int'(i_channel) < CHANNELS);
    assign w_addr     = AW'(i_channel);

    // Start time store, read at the channel number of the incoming transfer.
    mcssr_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (r_now),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Fraction divider for ramps still in progress.
    mcssr_div #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_elapsed),
        .i_den   (r_dur),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Elapsed time since the start, with an unarmed channel starting now.
    always_comb begin
        w_start   = r_armed[r_addr] ? w_rdata : r_now;
        w_elapsed = r_now - w_start;
        w_full    = (r_dur == '0) || (w_elapsed >= r_dur);
    end

    // The output register can take a result when empty or being drained.
    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_opcode == OP_QUERY)) begin
                    n_state = w_ch_ok ? ST_READ : ST_FIN;
                end
            end
            ST_READ: begin
                n_state = w_full ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs: armed bits, RAM write, divider start, result value.
    always_comb begin
        n_armed     = r_armed;
        n_frac      = r_frac;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_ch_ok && (i_opcode == OP_RELEASE)) begin
                    n_armed[w_addr] = 1'b0;
                end
                n_frac = '0;
            end
            ST_READ: begin
                if (!r_armed[r_addr]) begin
                    w_we            = 1'b1;
                    n_armed[r_addr] = 1'b1;
                end
                w_div_start = !w_full;
                n_frac      = FULL_SCALE;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_frac = {1'b0, w_quot};
                end
            end
            ST_FIN: begin
                n_frac = r_frac;
            end
            default: begin
                n_frac = r_frac;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr <= w_addr;
            r_dur  <= i_duration_us;
            r_now  <= i_now_us;
        end
        r_frac <= n_frac;
        if (w_load_out) begin
            r_out_frac <= r_frac;
            r_out_done <= (r_frac == FULL_SCALE);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ramp_fraction = r_out_frac;
    assign o_ramp_done     = r_out_done;

endmodule
